### design/mmpd_pkg.sv
// Shared types, constants and helper functions of the ramped PWM motor drive.
`timescale 1ns / 1ps
package mmpd_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int SLOT_W      = 2;
    localparam int MASK_W      = 4;
    localparam int THR_COUNT   = 4;
    localparam int THR_W       = 7;
    localparam int SPEED_W     = 8;
    localparam int MAG_W       = 7;
    localparam int STEP_W      = 8;
    localparam int VOLT_W      = 16;
    localparam int FACT_W      = 9;
    localparam int FRAC_W      = 8;
    localparam int DIV_W       = VOLT_W + FRAC_W;
    localparam int CNT_W       = 5;
    localparam int PWM_W       = 8;

    localparam int SPEED_MAX   = 100;
    localparam int FACT_MIN    = 204;
    localparam int FACT_MAX    = 333;
    localparam int FACT_ONE    = 256;
    localparam int BATT_MIN    = 100;
    localparam int PWM_FULL    = 255;
    // x / 100 == (x * 5243) >> 19 for every x below 43699
    localparam int RECIP       = 5243;
    localparam int RECIP_SH    = 19;

    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;

    typedef enum logic [1:0] {
        K_SET      = 2'd0,
        K_STOP_ONE = 2'd1,
        K_STOP_ALL = 2'd2,
        K_TICK     = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_WALK,
        S_RAMP,
        S_SCALE,
        S_EMIT,
        S_STOP
    } t_state;

    typedef enum logic [2:0] {
        R_USED   = 3'd0,
        R_BRIDGE = 3'd1,
        R_RAMP   = 3'd2,
        R_THR0   = 3'd3,
        R_THR1   = 3'd4,
        R_THR2   = 3'd5,
        R_THR3   = 3'd6,
        R_NOM    = 3'd7
    } t_reg;

    typedef struct packed {
        t_kind               kind;
        logic [SLOT_W-1:0]   motor;
        logic signed [7:0]   target_value;
        logic [VOLT_W-1:0]   battery_mv;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0]   motor_id;
        logic [PWM_W-1:0]    pwm;
        logic                drive_a;
        logic                drive_b;
        logic signed [7:0]   current_speed;
        logic signed [7:0]   target_speed;
        logic                last;
    } t_out;

    typedef struct packed {
        logic [MASK_W-1:0]                  used;
        logic [MASK_W-1:0]                  bridge;
        logic [STEP_W-1:0]                  ramp;
        logic [THR_COUNT-1:0][THR_W-1:0]    thr;
        logic [VOLT_W-1:0]                  nom;
    } t_cfg;

    typedef struct packed {
        logic              capture;
        logic              set_tgt;
        logic              div_start;
        logic              ramp;
        logic              scale;
        logic              emit_tick;
        logic              emit_stop;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_stat;

    function automatic logic slot_en(input logic [MASK_W-1:0] used,
                                     input logic [SLOT_W-1:0] m);
        return (int'(m) < MOTOR_COUNT) && used[m];
    endfunction

    // any enabled slot above m
    function automatic logic above_en(input logic [MASK_W-1:0] used,
                                      input logic [SLOT_W-1:0] m);
        logic r;
        r = 1'b0;
        for (int j = 0; j < MASK_W; j++) begin
            if ((j > int'(m)) && (j < MOTOR_COUNT) && used[j]) begin
                r = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [PWM_W-1:0] pwm_of(input logic [MAG_W-1:0] mag);
        logic [14:0] x;
        logic [27:0] p;
        x = 15'(mag) * 15'(PWM_FULL);
        p = 28'(x) * 28'(RECIP);
        return p[RECIP_SH +: PWM_W];
    endfunction

endpackage

### design/multi_motor_ramped_pwm_drive.sv
// Top level: register port, sequencer and datapath of the ramped PWM motor drive.
// Set request: taken while idle, gives no record. Stop one on an enabled slot: a record from the stop state.
// Tick: factor division, then walk, ramp, scale and emit states per enabled motor, walk
// only per skipped slot; stop all: walk and stop states per enabled motor, walk per skipped.
// One request at a time: ready returns as the last record is registered.
// Synchronous active-low reset clears speeds, sets registers to defaults, empties output.
`timescale 1ns / 1ps
module multi_motor_ramped_pwm_drive (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mmpd_pkg::t_in                 i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mmpd_pkg::t_out                o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mmpd_pkg::APB_AW-1:0]   paddr,
    input  logic [mmpd_pkg::APB_DW-1:0]   pwdata,
    output logic [mmpd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    mmpd_pkg::t_cfg  r_cfg;
    mmpd_pkg::t_cmd  cmd;
    mmpd_pkg::t_stat stat;
    mmpd_pkg::t_reg  reg_sel;
    logic            wr_en;

    assign pready  = 1'b1;
    assign reg_sel = mmpd_pkg::t_reg'(paddr[mmpd_pkg::APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.used   <= '0;
            r_cfg.bridge <= '0;
            r_cfg.ramp   <= mmpd_pkg::STEP_W'(5);
            r_cfg.thr    <= '0;
            r_cfg.nom    <= mmpd_pkg::VOLT_W'(12000);
        end else if (wr_en) begin
            unique case (reg_sel)
                mmpd_pkg::R_USED:   r_cfg.used   <= pwdata[mmpd_pkg::MASK_W-1:0];
                mmpd_pkg::R_BRIDGE: r_cfg.bridge <= pwdata[mmpd_pkg::MASK_W-1:0];
                mmpd_pkg::R_RAMP:   r_cfg.ramp   <= pwdata[mmpd_pkg::STEP_W-1:0];
                mmpd_pkg::R_THR0:   r_cfg.thr[0] <= pwdata[mmpd_pkg::THR_W-1:0];
                mmpd_pkg::R_THR1:   r_cfg.thr[1] <= pwdata[mmpd_pkg::THR_W-1:0];
                mmpd_pkg::R_THR2:   r_cfg.thr[2] <= pwdata[mmpd_pkg::THR_W-1:0];
                mmpd_pkg::R_THR3:   r_cfg.thr[3] <= pwdata[mmpd_pkg::THR_W-1:0];
                mmpd_pkg::R_NOM:    r_cfg.nom    <= pwdata[mmpd_pkg::VOLT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            mmpd_pkg::R_USED:   prdata = mmpd_pkg::APB_DW'(r_cfg.used);
            mmpd_pkg::R_BRIDGE: prdata = mmpd_pkg::APB_DW'(r_cfg.bridge);
            mmpd_pkg::R_RAMP:   prdata = mmpd_pkg::APB_DW'(r_cfg.ramp);
            mmpd_pkg::R_THR0:   prdata = mmpd_pkg::APB_DW'(r_cfg.thr[0]);
            mmpd_pkg::R_THR1:   prdata = mmpd_pkg::APB_DW'(r_cfg.thr[1]);
            mmpd_pkg::R_THR2:   prdata = mmpd_pkg::APB_DW'(r_cfg.thr[2]);
            mmpd_pkg::R_THR3:   prdata = mmpd_pkg::APB_DW'(r_cfg.thr[3]);
            mmpd_pkg::R_NOM:    prdata = mmpd_pkg::APB_DW'(r_cfg.nom);
            default:            prdata = '0;
        endcase
    end

    mmpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mmpd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_no_both_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.drive_a && o_out.drive_b))
        else $error("both bridge lines driven high");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.current_speed <= 8'sd100) &&
                        (o_out.current_speed >= -8'sd100))
        else $error("reported speed out of range");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.div_busy |-> !o_in_ready)
        else $error("request taken during factor division");

    a_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in.kind == mmpd_pkg::K_TICK)) |=> !o_in_ready)
        else $error("tick request did not hold off input");
`endif

endmodule

### design/mmpd_ctrl.sv
// Sequencer of the motor drive: decodes requests and walks the motor slots.
`timescale 1ns / 1ps
module mmpd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mmpd_pkg::t_in   i_in,
    input  mmpd_pkg::t_cfg  i_cfg,
    input  mmpd_pkg::t_stat i_stat,
    output mmpd_pkg::t_cmd  o_cmd
);

    mmpd_pkg::t_state                r_state, n_state;
    mmpd_pkg::t_kind                 r_kind, n_kind;
    logic [mmpd_pkg::SLOT_W-1:0]     r_slot, n_slot;
    logic                            cur_en;
    logic                            is_top;
    logic                            last_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmpd_pkg::S_IDLE;
            r_kind  <= mmpd_pkg::K_SET;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_slot  <= n_slot;
        end
    end

    assign cur_en   = mmpd_pkg::slot_en(i_cfg.used, r_slot);
    assign is_top   = (r_slot == mmpd_pkg::SLOT_W'(mmpd_pkg::MOTOR_COUNT - 1));
    assign last_rec = (r_kind == mmpd_pkg::K_STOP_ONE) ||
                      !mmpd_pkg::above_en(i_cfg.used, r_slot);
    assign o_in_ready = (r_state == mmpd_pkg::S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_slot     = r_slot;
        o_cmd      = '0;
        o_cmd.slot = r_slot;
        o_cmd.last = last_rec;
        unique case (r_state)
            mmpd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_kind        = i_in.kind;
                    unique case (i_in.kind)
                        mmpd_pkg::K_SET: begin
                            o_cmd.slot    = i_in.motor;
                            o_cmd.set_tgt = mmpd_pkg::slot_en(i_cfg.used, i_in.motor);
                        end
                        mmpd_pkg::K_STOP_ONE: begin
                            if (mmpd_pkg::slot_en(i_cfg.used, i_in.motor)) begin
                                n_slot  = i_in.motor;
                                n_state = mmpd_pkg::S_STOP;
                            end
                        end
                        mmpd_pkg::K_STOP_ALL: begin
                            n_slot  = '0;
                            n_state = mmpd_pkg::S_WALK;
                        end
                        mmpd_pkg::K_TICK: begin
                            o_cmd.div_start = 1'b1;
                            n_state         = mmpd_pkg::S_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            mmpd_pkg::S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_slot  = '0;
                    n_state = mmpd_pkg::S_WALK;
                end
            end
            mmpd_pkg::S_WALK: begin
                if (cur_en) begin
                    n_state = (r_kind == mmpd_pkg::K_TICK) ? mmpd_pkg::S_RAMP
                                                           : mmpd_pkg::S_STOP;
                end else if (is_top) begin
                    n_state = mmpd_pkg::S_IDLE;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            mmpd_pkg::S_RAMP: begin
                o_cmd.ramp = 1'b1;
                n_state    = mmpd_pkg::S_SCALE;
            end
            mmpd_pkg::S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = mmpd_pkg::S_EMIT;
            end
            mmpd_pkg::S_EMIT, mmpd_pkg::S_STOP: begin
                // hold until the output register can take the record
                if (i_stat.out_free) begin
                    o_cmd.emit_tick = (r_state == mmpd_pkg::S_EMIT);
                    o_cmd.emit_stop = (r_state == mmpd_pkg::S_STOP);
                    if (last_rec) begin
                        n_state = mmpd_pkg::S_IDLE;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = mmpd_pkg::S_WALK;
                    end
                end
            end
            default: n_state = mmpd_pkg::S_IDLE;
        endcase
    end

endmodule

### design/mmpd_dp.sv
// Datapath of the motor drive: speed store, factor divider, ramp, scaling, output register.
`timescale 1ns / 1ps
module mmpd_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mmpd_pkg::t_in   i_in,
    input  mmpd_pkg::t_cfg  i_cfg,
    input  mmpd_pkg::t_cmd  i_cmd,
    input  logic            i_out_ready,
    output mmpd_pkg::t_stat o_stat,
    output logic            o_out_valid,
    output mmpd_pkg::t_out  o_out
);

    logic signed [mmpd_pkg::SPEED_W-1:0] r_cur [mmpd_pkg::MOTOR_COUNT];
    logic signed [mmpd_pkg::SPEED_W-1:0] r_tgt [mmpd_pkg::MOTOR_COUNT];

    logic [mmpd_pkg::VOLT_W-1:0]  r_batt;
    logic [mmpd_pkg::VOLT_W-1:0]  r_rem;
    logic [mmpd_pkg::DIV_W-1:0]   r_quo;
    logic [mmpd_pkg::CNT_W-1:0]   r_cnt;

    logic [mmpd_pkg::MAG_W-1:0]          r_mag;
    logic [mmpd_pkg::MAG_W-1:0]          r_smag;
    logic signed [mmpd_pkg::SPEED_W-1:0] r_cur_s;
    logic signed [mmpd_pkg::SPEED_W-1:0] r_tgt_s;

    logic           r_out_valid;
    mmpd_pkg::t_out r_out;

    logic signed [mmpd_pkg::SPEED_W-1:0] cur, tgt, new_cur, set_val;
    logic signed [mmpd_pkg::SPEED_W:0]   cur9, tgt9, diff, step9, new9;
    logic [mmpd_pkg::SPEED_W:0]          adiff;
    logic [mmpd_pkg::SPEED_W-1:0]        new_abs;
    logic [mmpd_pkg::MAG_W-1:0]          mag;
    logic [mmpd_pkg::FACT_W-1:0]         quo_cl, factor;
    logic [mmpd_pkg::MAG_W+mmpd_pkg::FACT_W-1:0] prod;
    logic [mmpd_pkg::SPEED_W-1:0]        scaled;
    logic [mmpd_pkg::VOLT_W:0]           rem_sh, rem_sub;
    logic                                qbit;

    // ramp toward target by at most the step
    always_comb begin
        cur   = r_cur[i_cmd.slot];
        tgt   = r_tgt[i_cmd.slot];
        cur9  = {cur[mmpd_pkg::SPEED_W-1], cur};
        tgt9  = {tgt[mmpd_pkg::SPEED_W-1], tgt};
        step9 = {1'b0, i_cfg.ramp};
        diff  = tgt9 - cur9;
        adiff = diff[mmpd_pkg::SPEED_W] ? (~diff + 1'b1) : diff;
        if (adiff <= step9) begin
            new9 = tgt9;
        end else if (!diff[mmpd_pkg::SPEED_W]) begin
            new9 = cur9 + step9;
        end else begin
            new9 = cur9 - step9;
        end
        new_cur = new9[mmpd_pkg::SPEED_W-1:0];
        new_abs = new_cur[mmpd_pkg::SPEED_W-1] ? (~new_cur + 1'b1) : new_cur;
        mag     = new_abs[mmpd_pkg::MAG_W-1:0];
        if (mag < i_cfg.thr[i_cmd.slot]) begin
            mag = '0;
        end
    end

    // clamp the requested target
    always_comb begin
        if (i_in.target_value > 8'sd100) begin
            set_val = 8'sd100;
        end else if (i_in.target_value < -8'sd100) begin
            set_val = -8'sd100;
        end else begin
            set_val = i_in.target_value;
        end
    end

    // battery compensation factor and scaled magnitude
    always_comb begin
        if (r_quo > mmpd_pkg::DIV_W'(mmpd_pkg::FACT_MAX)) begin
            quo_cl = mmpd_pkg::FACT_W'(mmpd_pkg::FACT_MAX);
        end else if (r_quo < mmpd_pkg::DIV_W'(mmpd_pkg::FACT_MIN)) begin
            quo_cl = mmpd_pkg::FACT_W'(mmpd_pkg::FACT_MIN);
        end else begin
            quo_cl = r_quo[mmpd_pkg::FACT_W-1:0];
        end
        factor = (r_batt <= mmpd_pkg::VOLT_W'(mmpd_pkg::BATT_MIN))
               ? mmpd_pkg::FACT_W'(mmpd_pkg::FACT_ONE) : quo_cl;
        prod   = (mmpd_pkg::MAG_W + mmpd_pkg::FACT_W)'(r_mag) *
                 (mmpd_pkg::MAG_W + mmpd_pkg::FACT_W)'(factor);
        scaled = prod[mmpd_pkg::FRAC_W +: mmpd_pkg::SPEED_W];
    end

    // one restoring division step per cycle
    always_comb begin
        rem_sh  = {r_rem, r_quo[mmpd_pkg::DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_batt};
        qbit    = (rem_sh >= {1'b0, r_batt});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mmpd_pkg::MOTOR_COUNT; i++) begin
                r_cur[i] <= '0;
                r_tgt[i] <= '0;
            end
        end else begin
            if (i_cmd.set_tgt) begin
                r_tgt[i_cmd.slot] <= set_val;
            end
            if (i_cmd.emit_stop) begin
                r_cur[i_cmd.slot] <= '0;
                r_tgt[i_cmd.slot] <= '0;
            end
            if (i_cmd.ramp) begin
                r_cur[i_cmd.slot] <= new_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_cnt <= mmpd_pkg::CNT_W'(mmpd_pkg::DIV_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_batt <= i_in.battery_mv;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= {i_cfg.nom, mmpd_pkg::FRAC_W'(0)};
        end else if (r_cnt != '0) begin
            r_rem <= qbit ? rem_sub[mmpd_pkg::VOLT_W-1:0] : rem_sh[mmpd_pkg::VOLT_W-1:0];
            r_quo <= {r_quo[mmpd_pkg::DIV_W-2:0], qbit};
        end
        if (i_cmd.ramp) begin
            r_mag   <= mag;
            r_cur_s <= new_cur;
            r_tgt_s <= tgt;
        end
        if (i_cmd.scale) begin
            r_smag <= (scaled > mmpd_pkg::SPEED_W'(mmpd_pkg::SPEED_MAX))
                    ? mmpd_pkg::MAG_W'(mmpd_pkg::SPEED_MAX)
                    : scaled[mmpd_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_tick || i_cmd.emit_stop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_tick) begin
            r_out.motor_id      <= i_cmd.slot;
            r_out.pwm           <= mmpd_pkg::pwm_of(r_smag);
            r_out.drive_a       <= !r_cur_s[mmpd_pkg::SPEED_W-1];
            r_out.drive_b       <= i_cfg.bridge[i_cmd.slot] & r_cur_s[mmpd_pkg::SPEED_W-1];
            r_out.current_speed <= r_cur_s;
            r_out.target_speed  <= r_tgt_s;
            r_out.last          <= i_cmd.last;
        end else if (i_cmd.emit_stop) begin
            r_out.motor_id      <= i_cmd.slot;
            r_out.pwm           <= '0;
            r_out.drive_a       <= 1'b0;
            r_out.drive_b       <= 1'b0;
            r_out.current_speed <= '0;
            r_out.target_speed  <= '0;
            r_out.last          <= i_cmd.last;
        end
    end

    assign o_stat.div_busy = (r_cnt != '0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

endmodule

### verif/tb.sv
// Self-checking testbench for the ramped PWM motor drive: random requests, scoreboarded records.
`timescale 1ns / 1ps
module tb;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYC  = 64;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_REQS  = 47;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        o_in_ready;
    mmpd_pkg::t_in               in_req = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    mmpd_pkg::t_out              drive_rec;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [mmpd_pkg::APB_AW-1:0] paddr = '0;
    logic [mmpd_pkg::APB_DW-1:0] pwdata = '0;
    logic [mmpd_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    // register copies, written by the stimulus process only while the block is idle
    logic [3:0]        used_mask = 4'd0;
    logic [3:0]        bridge_mask = 4'd0;
    logic [7:0]        ramp_step = 8'd5;
    logic [6:0]        thr [mmpd_pkg::MOTOR_COUNT] = '{default: 7'd0};
    logic [15:0]       nom_mv = 16'd12000;

    logic signed [7:0] cur_spd [mmpd_pkg::MOTOR_COUNT] = '{default: 8'sd0};
    logic signed [7:0] tgt_spd [mmpd_pkg::MOTOR_COUNT] = '{default: 8'sd0};

    mmpd_pkg::t_in     pending_reqs [$];
    mmpd_pkg::t_out    expected_drives [$];
    int                reqs_queued = 0;
    int                reqs_taken = 0;
    int                fail_count = 0;
    int                idle_cycles = 0;
    int                in_gap = 0;
    int                out_stall = 0;
    logic              calm = 1'b0;

    multi_motor_ramped_pwm_drive u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (drive_rec),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 i_clk = ~i_clk;

    // apply one accepted request to the speed state and queue the records it gives
    task automatic predict_drive(input mmpd_pkg::t_in req);
        mmpd_pkg::t_out rec [mmpd_pkg::MOTOR_COUNT];
        int   n;
        int   tv;
        int   cur;
        int   tgt;
        int   diff;
        int   adiff;
        int   mag;
        int   factor;
        logic fwd;
        n = 0;
        case (req.kind)
            mmpd_pkg::K_SET: begin
                if (used_mask[req.motor]) begin
                    tv = int'(req.target_value);
                    if (tv > mmpd_pkg::SPEED_MAX) tv = mmpd_pkg::SPEED_MAX;
                    if (tv < -mmpd_pkg::SPEED_MAX) tv = -mmpd_pkg::SPEED_MAX;
                    tgt_spd[req.motor] = 8'(tv);
                end
            end
            mmpd_pkg::K_STOP_ONE: begin
                if (used_mask[req.motor]) begin
                    cur_spd[req.motor] = '0;
                    tgt_spd[req.motor] = '0;
                    rec[0] = '0;
                    rec[0].motor_id = req.motor;
                    n = 1;
                end
            end
            mmpd_pkg::K_STOP_ALL: begin
                for (int i = 0; i < mmpd_pkg::MOTOR_COUNT; i++) begin
                    if (used_mask[i]) begin
                        cur_spd[i] = '0;
                        tgt_spd[i] = '0;
                        rec[n] = '0;
                        rec[n].motor_id = 2'(i);
                        n++;
                    end
                end
            end
            mmpd_pkg::K_TICK: begin
                factor = mmpd_pkg::FACT_ONE;
                if (int'(req.battery_mv) > mmpd_pkg::BATT_MIN) begin
                    factor = (int'(nom_mv) * 256) / int'(req.battery_mv);
                    if (factor < mmpd_pkg::FACT_MIN) factor = mmpd_pkg::FACT_MIN;
                    if (factor > mmpd_pkg::FACT_MAX) factor = mmpd_pkg::FACT_MAX;
                end
                for (int i = 0; i < mmpd_pkg::MOTOR_COUNT; i++) begin
                    if (used_mask[i]) begin
                        cur = int'(cur_spd[i]);
                        tgt = int'(tgt_spd[i]);
                        diff = tgt - cur;
                        adiff = (diff < 0) ? -diff : diff;
                        if (adiff <= int'(ramp_step)) cur = tgt;
                        else if (diff > 0) cur += int'(ramp_step);
                        else cur -= int'(ramp_step);
                        cur_spd[i] = 8'(cur);
                        mag = (cur < 0) ? -cur : cur;
                        if (mag < int'(thr[i]) && cur != 0) mag = 0;
                        mag = (mag * factor) >> 8;
                        if (mag > mmpd_pkg::SPEED_MAX) mag = mmpd_pkg::SPEED_MAX;
                        fwd = (cur >= 0);
                        rec[n] = '0;
                        rec[n].motor_id = 2'(i);
                        rec[n].pwm = 8'((mag * mmpd_pkg::PWM_FULL) / 100);
                        rec[n].drive_a = fwd;
                        rec[n].drive_b = bridge_mask[i] ? ~fwd : 1'b0;
                        rec[n].current_speed = 8'(cur);
                        rec[n].target_speed = 8'(tgt);
                        n++;
                    end
                end
            end
            default: ;
        endcase
        for (int k = 0; k < n; k++) begin
            rec[k].last = (k == n - 1);
            expected_drives.push_back(rec[k]);
        end
    endtask

    always @(posedge i_clk) begin : driver
        logic          next_valid;
        mmpd_pkg::t_in next_req;
        next_valid = in_valid;
        next_req = in_req;
        if (!i_rst_n) begin
            next_valid = 1'b0;
            in_gap = 0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_drive(in_req);
                reqs_taken++;
                next_valid = 1'b0;
                if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 16);
            end
            if (!next_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_reqs.size() > 0) begin
                    next_req = pending_reqs.pop_front();
                    next_valid = 1'b1;
                end
            end
        end
        in_valid <= next_valid;
        in_req <= next_req;
    end

    always @(posedge i_clk) begin : sink
        logic next_ready;
        if (!i_rst_n) begin
            out_stall = 0;
            next_ready = 1'b1;
        end else if (out_stall > 0) begin
            out_stall--;
            next_ready = 1'b0;
        end else if (!i_out_ready) begin
            next_ready = 1'b1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            out_stall = $urandom_range(0, 15);
            next_ready = 1'b0;
        end else begin
            next_ready = 1'b1;
        end
        i_out_ready <= next_ready;
    end

    function automatic int field_diff(input string name, input int want, input int got);
        if (want != got) begin
            $display("[%0t] %s mismatch: expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : monitor
        mmpd_pkg::t_out want;
        int             bad;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_drives.size() == 0) begin
                $display("[%0t] unexpected record: motor %0d pwm %0d", $time,
                         drive_rec.motor_id, drive_rec.pwm);
                fail_count++;
            end else begin
                want = expected_drives.pop_front();
                bad = field_diff("motor_id", want.motor_id, drive_rec.motor_id)
                    + field_diff("pwm", want.pwm, drive_rec.pwm)
                    + field_diff("drive_a", want.drive_a, drive_rec.drive_a)
                    + field_diff("drive_b", want.drive_b, drive_rec.drive_b)
                    + field_diff("current_speed", want.current_speed,
                                 drive_rec.current_speed)
                    + field_diff("target_speed", want.target_speed, drive_rec.target_speed)
                    + field_diff("last", want.last, drive_rec.last);
                if (bad != 0) fail_count++;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic reg_write(input mmpd_pkg::t_reg r, input logic [mmpd_pkg::APB_DW-1:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            mmpd_pkg::R_USED:   used_mask = v[3:0];
            mmpd_pkg::R_BRIDGE: bridge_mask = v[3:0];
            mmpd_pkg::R_RAMP:   ramp_step = v[7:0];
            mmpd_pkg::R_NOM:    nom_mv = v[15:0];
            default:            thr[int'(r) - int'(mmpd_pkg::R_THR0)] = v[6:0];
        endcase
    endtask

    task automatic configure(input logic [3:0] used, input logic [3:0] bridge,
                             input logic [7:0] ramp, input logic [3:0][6:0] thr_set,
                             input logic [15:0] nom);
        reg_write(mmpd_pkg::R_USED, 32'(used));
        reg_write(mmpd_pkg::R_BRIDGE, 32'(bridge));
        reg_write(mmpd_pkg::R_RAMP, 32'(ramp));
        for (int i = 0; i < mmpd_pkg::MOTOR_COUNT; i++) begin
            reg_write(mmpd_pkg::t_reg'(int'(mmpd_pkg::R_THR0) + i), 32'(thr_set[i]));
        end
        reg_write(mmpd_pkg::R_NOM, 32'(nom));
        @(negedge i_clk);
    endtask

    task automatic send(input mmpd_pkg::t_kind k, input int m, input int tv, input int batt);
        mmpd_pkg::t_in req;
        req.kind = k;
        req.motor = 2'(m);
        req.target_value = 8'(tv);
        req.battery_mv = 16'(batt);
        pending_reqs.push_back(req);
        reqs_queued++;
    endtask

    // hold until every request is taken and every record is back, then let the block settle
    task automatic settle_idle();
        while (reqs_taken != reqs_queued || expected_drives.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic send_random();
        int              pick;
        int              m;
        int              tv;
        int              batt;
        mmpd_pkg::t_kind k;
        pick = $urandom_range(0, 99);
        if (pick < 40) k = mmpd_pkg::K_SET;
        else if (pick < 85) k = mmpd_pkg::K_TICK;
        else if (pick < 93) k = mmpd_pkg::K_STOP_ONE;
        else k = mmpd_pkg::K_STOP_ALL;
        m = $urandom_range(0, 3);
        // steer most set and stop requests onto enabled slots
        repeat (3) begin
            if (!used_mask[m]) m = $urandom_range(0, 3);
        end
        if ($urandom_range(0, 1) == 0) tv = $urandom_range(0, 255);
        else tv = int'($urandom_range(0, 200)) - 100;
        pick = $urandom_range(0, 9);
        if (pick == 0) batt = $urandom_range(0, 100);
        else if (pick == 1) batt = $urandom_range(0, 65535);
        else batt = int'(nom_mv) * int'($urandom_range(70, 130)) / 100;
        if (batt > 65535) batt = 65535;
        send(k, m, tv, batt);
    endtask

    initial begin : stimulus
        logic [3:0][6:0] thr_set;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // nothing enabled after reset: every request is dropped or gives nothing
        send(mmpd_pkg::K_TICK, 0, 0, 12000);
        send(mmpd_pkg::K_STOP_ALL, 0, 0, 0);
        send(mmpd_pkg::K_SET, 0, 50, 0);
        send(mmpd_pkg::K_STOP_ONE, 0, 0, 0);
        settle_idle();

        configure(4'hF, 4'b0101, 8'd200, '0, 16'd12000);
        send(mmpd_pkg::K_SET, 0, 127, 0);
        send(mmpd_pkg::K_SET, 1, -128, 0);
        send(mmpd_pkg::K_SET, 2, 0, 0);
        send(mmpd_pkg::K_SET, 3, -1, 0);
        send(mmpd_pkg::K_TICK, 0, 0, 12000);
        send(mmpd_pkg::K_TICK, 0, 0, 0);
        send(mmpd_pkg::K_SET, 0, -100, 0);
        send(mmpd_pkg::K_SET, 1, 100, 0);
        send(mmpd_pkg::K_SET, 3, 1, 0);
        send(mmpd_pkg::K_TICK, 0, 0, 100);
        send(mmpd_pkg::K_TICK, 0, 0, 101);
        send(mmpd_pkg::K_TICK, 0, 0, 65535);
        send(mmpd_pkg::K_STOP_ONE, 1, 0, 0);
        send(mmpd_pkg::K_TICK, 0, 0, 6000);
        send(mmpd_pkg::K_STOP_ALL, 0, 0, 0);
        send(mmpd_pkg::K_TICK, 0, 0, 24000);
        settle_idle();

        // disabled slots ignore set and stop; thresholds at and above full scale
        configure(4'b1010, 4'b1010, 8'd255, {7'd127, 7'd101, 7'd100, 7'd50}, 16'hFFFF);
        send(mmpd_pkg::K_SET, 0, 90, 0);
        send(mmpd_pkg::K_STOP_ONE, 2, 0, 0);
        send(mmpd_pkg::K_SET, 1, -60, 0);
        send(mmpd_pkg::K_SET, 3, 70, 0);
        send(mmpd_pkg::K_TICK, 0, 0, 101);
        settle_idle();

        // zero ramp freezes the speeds, zero nominal clamps the factor low
        configure(4'hF, 4'b0000, 8'd0, '0, 16'd0);
        send(mmpd_pkg::K_SET, 1, -20, 0);
        send(mmpd_pkg::K_TICK, 0, 0, 5000);
        send(mmpd_pkg::K_TICK, 0, 0, 50);
        settle_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            for (int i = 0; i < mmpd_pkg::MOTOR_COUNT; i++) begin
                thr_set[i] = (p == 3) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 30));
            end
            if (p == RAND_PHASES - 1) calm = 1'b1;
            configure((p == RAND_PHASES - 1) ? 4'hF : 4'($urandom_range(1, 15)),
                      4'($urandom_range(0, 15)),
                      (p % 2 == 0) ? 8'($urandom_range(1, 20)) : 8'($urandom_range(0, 255)),
                      thr_set,
                      (p == 2) ? 16'd0 : (p == 3) ? 16'hFFFF
                                               : 16'($urandom_range(6000, 24000)));
            repeat (PHASE_REQS) send_random();
            settle_idle();
        end

        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
